>>> design/pati_pkg.sv
// ----------------------------------------------------------------------------
// pati_pkg
// Shared widths, constants, codes and types for the positive-area trapezoid
// integrator and its multiply/divide unit.
// ----------------------------------------------------------------------------
package pati_pkg;

    // Fixed-point format of samples and registers
    localparam int FRAC_BITS = 16;
    localparam int XW        = 32;

    // Multiply/divide unit operand widths
    localparam int OPA_W     = XW + 1;
    localparam int OPB_W     = 64;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int DIV_STEPS = OPB_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Result fields
    localparam int AREA_W    = 48;
    localparam int STAT_W    = 2;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 2 * XW;
    localparam int M_TDATA_W = ((AREA_W + STAT_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - AREA_W - STAT_W;

    // Saturation limits
    localparam logic [OPB_W-1:0]        CAP    = (64'd1 << 62) - 64'd1;
    localparam logic signed [OPB_W:0]   ACC_HI = (65'sd1 <<< 62) - 65'sd1;
    localparam logic signed [OPB_W:0]   ACC_LO = -ACC_HI;
    localparam logic signed [OPB_W-1:0] OUT_HI = (64'sd1 <<< (AREA_W - 1)) - 64'sd1;
    localparam logic signed [OPB_W-1:0] OUT_LO = -(64'sd1 <<< (AREA_W - 1));

    // Register reset values: upper limit 0.8, scale 1.0
    localparam logic signed [XW-1:0] UPPER_RESET = XW'((8 * (64'd1 << FRAC_BITS) + 5) / 10);
    localparam logic signed [XW-1:0] SCALE_RESET = XW'(64'd1 << FRAC_BITS);

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPPER   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_LIMIT   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_END     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SAT     = 2'd3;

    // Multiply/divide unit operations
    typedef enum logic [1:0] {
        MD_MUL,     // raw product, no saturation
        MD_SHIFT,   // product >> FRAC_BITS, capped
        MD_DIV      // product / c, capped
    } md_mode_t;

    typedef struct packed {
        logic              start;
        md_mode_t          mode;
        logic [OPA_W-1:0]  a;
        logic [OPB_W-1:0]  b;
        logic [OPB_W-1:0]  c;
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [OPB_W-1:0]  q;
    } md_rsp_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_MUL,
        MS_CHK,
        MS_DIV,
        MS_FIN
    } md_state_t;

    // Curve phase
    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_INTEG,
        PH_DONE
    } phase_t;

    // Top-level sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SQ,
        ST_CROSS,
        ST_TRAP,
        ST_INTERP,
        ST_PART,
        ST_ACC,
        ST_SCALE,
        ST_WAIT,
        ST_OUT
    } seq_state_t;

    // Magnitudes of two's-complement values
    function automatic logic [OPA_W-1:0] mag33(input logic signed [OPA_W-1:0] v);
        return v[OPA_W-1] ? OPA_W'(-v) : OPA_W'(v);
    endfunction

    function automatic logic [OPB_W-1:0] mag64(input logic signed [OPB_W-1:0] v);
        return v[OPB_W-1] ? OPB_W'(-v) : OPB_W'(v);
    endfunction

endpackage

>>> design/pati_mdu.sv
// ----------------------------------------------------------------------------
// pati_mdu
// Shared multiply/divide unit: shift-add multiply of 33- by 64-bit magnitudes;
// a constant shift or a restoring divide may follow, capped at 2^62-1.
// ----------------------------------------------------------------------------
module pati_mdu (
    input  logic              aclk,
    input  logic              aresetn,
    input  pati_pkg::md_req_t req,
    output pati_pkg::md_rsp_t rsp
);
    import pati_pkg::*;

    md_state_t           st_reg, st_next;
    md_mode_t            mode_reg, mode_next;
    logic [PROD_W-1:0]   p_reg, p_next;
    logic [OPB_W-1:0]    b_reg, b_next;
    logic [OPB_W-1:0]    c_reg, c_next;
    logic [OPB_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                satp_reg, satp_next;

    logic [OPB_W:0]      mul_sum;
    logic [OPB_W:0]      div_t;
    logic                div_ge;
    logic                hi_ovf;
    logic [PROD_W-1:0]   shf;

    // Step arithmetic
    always_comb begin
        mul_sum = {1'b0, p_reg[PROD_W-1:OPA_W]} + (p_reg[0] ? {1'b0, b_reg} : '0);
        div_t   = {rem_reg, p_reg[OPB_W-1]};
        div_ge  = (div_t >= {1'b0, c_reg});
        hi_ovf  = ({{(OPB_W-OPA_W){1'b0}}, p_reg[PROD_W-1:OPB_W]} >= c_reg);
        shf     = p_reg >> FRAC_BITS;
    end

    // Next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            MS_IDLE: if (req.start) begin
                st_next = MS_MUL;
            end
            MS_MUL: if (cnt_reg == '0) begin
                st_next = (mode_reg == MD_DIV) ? MS_CHK : MS_FIN;
            end
            MS_CHK:  st_next = hi_ovf ? MS_FIN : MS_DIV;
            MS_DIV: if (cnt_reg == '0) begin
                st_next = MS_FIN;
            end
            MS_FIN:  st_next = MS_IDLE;
            default: st_next = MS_IDLE;
        endcase
    end

    // Datapath and response
    always_comb begin
        mode_next = mode_reg;
        p_next    = p_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        satp_next = satp_reg;
        rsp       = '0;
        unique case (st_reg)
            MS_IDLE: if (req.start) begin
                mode_next = req.mode;
                p_next    = {{OPB_W{1'b0}}, req.a};
                b_next    = req.b;
                c_next    = req.c;
                cnt_next  = CNT_W'(OPA_W - 1);
                satp_next = 1'b0;
            end
            MS_MUL: begin
                p_next   = {mul_sum, p_reg[OPA_W-1:1]};
                cnt_next = cnt_reg - 1'b1;
            end
            MS_CHK: begin
                if (hi_ovf) begin
                    p_next[OPB_W-1:0] = CAP;
                    satp_next         = 1'b1;
                end else begin
                    rem_next = {{(OPB_W-OPA_W){1'b0}}, p_reg[PROD_W-1:OPB_W]};
                    cnt_next = CNT_W'(DIV_STEPS - 1);
                end
            end
            MS_DIV: begin
                rem_next          = div_ge ? OPB_W'(div_t - {1'b0, c_reg}) : div_t[OPB_W-1:0];
                p_next[OPB_W-1:0] = {p_reg[OPB_W-2:0], div_ge};
                cnt_next          = cnt_reg - 1'b1;
            end
            MS_FIN: begin
                rsp.done = 1'b1;
                unique case (mode_reg)
                    MD_MUL: begin
                        rsp.q = p_reg[OPB_W-1:0];
                    end
                    MD_SHIFT: begin
                        rsp.sat = (shf > {{(PROD_W-OPB_W){1'b0}}, CAP});
                        rsp.q   = rsp.sat ? CAP : shf[OPB_W-1:0];
                    end
                    MD_DIV: begin
                        rsp.sat = satp_reg || (p_reg[OPB_W-1:0] > CAP);
                        rsp.q   = rsp.sat ? CAP : p_reg[OPB_W-1:0];
                    end
                    default: rsp.q = '0;
                endcase
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= MS_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        p_reg    <= p_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        satp_reg <= satp_next;
    end

endmodule

>>> design/positive_area_trapezoid_integrator.sv
// ----------------------------------------------------------------------------
// positive_area_trapezoid_integrator
// Integrates the positive part of a streamed (x, y) curve with trapezoids,
// zero-crossing triangles and an interpolated final segment, then scales.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Contents
//  s_       in         tvalid/tready      tdata: sample_x, sample_y; tlast
//  m_       out        tvalid/tready      tdata: area, status
//  cfg_     in         cfg_wr_en          cfg_addr, cfg_wdata (start_x,
//                                         upper_limit, scale)
//
//  One sample at a time: s_tready is high only while the sequencer is idle.
//  A skipped sample is only checked; a trapezoid takes one multiply, a zero
//  crossing a multiply and a multiply-divide; closing a curve adds a scaling
//  multiply and the result load, and the final interpolated segment takes a
//  multiply-divide and a multiply. Every product and quotient runs through
//  one shift-add/restoring-divide unit. A result sits in the output register
//  while the next sample is taken; a sample that ends in a result waits while
//  that register is still full. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module positive_area_trapezoid_integrator (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sample word
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pati_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] sample_x, [63:32] sample_y
    input  logic                               s_tlast,   // last_sample
    // result word
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pati_pkg::M_TDATA_W-1:0]     m_tdata,   // [47:0] area, [49:48] status
    // register writes
    input  logic                               cfg_wr_en,
    input  logic [pati_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pati_pkg::XW-1:0]            cfg_wdata
);
    import pati_pkg::*;

    seq_state_t                state_reg, state_next;
    seq_state_t                ret_reg, ret_next;
    phase_t                    phase_reg, phase_next;

    logic signed [XW-1:0]      start_x_reg, upper_reg, scale_reg;
    logic signed [XW-1:0]      prev_x_reg, prev_x_next;
    logic signed [XW-1:0]      prev_y_reg, prev_y_next;
    logic signed [OPB_W-1:0]   acc_reg, acc_next;
    logic                      sat_reg, sat_next;

    logic signed [XW-1:0]      x1_reg, x1_next;
    logic signed [XW-1:0]      y1_reg, y1_next;
    logic                      last_reg, last_next;
    logic signed [XW-1:0]      y0_reg, y0_next;
    logic signed [OPA_W-1:0]   dx_reg, dx_next;
    logic signed [OPA_W-1:0]   alim_reg, alim_next;
    logic signed [OPB_W-1:0]   tmp_reg, tmp_next;
    logic                      neg_reg, neg_next;
    logic                      emit_reg, emit_next;
    logic [STAT_W-1:0]         stat_reg, stat_next;

    logic [AREA_W-1:0]         area_reg, area_next;
    logic [STAT_W-1:0]         status_reg, status_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    md_req_t                   md_req;
    md_rsp_t                   md_rsp;

    logic signed [OPA_W-1:0]   eval_dx, eval_alim;
    logic                      start_hit, below_limit, any_pos, crossing;
    logic signed [OPA_W-1:0]   ysum, ydiff, ygap;
    logic signed [XW-1:0]      yp, yn;
    logic signed [OPB_W-1:0]   psum;
    logic signed [OPB_W:0]     acc_sum;
    logic                      out_free, out_ovf;
    logic signed [OPB_W-1:0]   out_val;

    pati_mdu u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    // Segment terms and checks
    always_comb begin
        eval_dx     = {x1_reg[XW-1], x1_reg} - {prev_x_reg[XW-1], prev_x_reg};
        eval_alim   = {upper_reg[XW-1], upper_reg} - {prev_x_reg[XW-1], prev_x_reg};
        start_hit   = (x1_reg == start_x_reg);
        below_limit = (x1_reg < upper_reg);
        any_pos     = (prev_y_reg > 0) || (y1_reg > 0);
        crossing    = prev_y_reg[XW-1] || y1_reg[XW-1];

        ysum  = {y0_reg[XW-1], y0_reg} + {y1_reg[XW-1], y1_reg};
        ydiff = {y1_reg[XW-1], y1_reg} - {y0_reg[XW-1], y0_reg};
        yp    = y0_reg[XW-1] ? y1_reg : y0_reg;
        yn    = y0_reg[XW-1] ? y0_reg : y1_reg;
        ygap  = {yp[XW-1], yp} - {yn[XW-1], yn};
        psum  = tmp_reg + $signed({{(OPB_W-XW-1){y0_reg[XW-1]}}, y0_reg, 1'b0});

        acc_sum  = {acc_reg[OPB_W-1], acc_reg} + {tmp_reg[OPB_W-1], tmp_reg};
        out_free = !m_tvalid_reg || m_tready;

        out_ovf = 1'b1;
        if (tmp_reg > OUT_HI) begin
            out_val = OUT_HI;
        end else if (tmp_reg < OUT_LO) begin
            out_val = OUT_LO;
        end else begin
            out_val = tmp_reg;
            out_ovf = 1'b0;
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                priority if (phase_reg == PH_SEARCH) begin
                    if (start_hit) begin
                        state_next = last_reg ? ST_SCALE : ST_IDLE;
                    end else begin
                        state_next = last_reg ? ST_OUT : ST_IDLE;
                    end
                end else if (phase_reg == PH_INTEG) begin
                    if (below_limit) begin
                        if (any_pos) begin
                            state_next = crossing ? ST_SQ : ST_TRAP;
                        end else begin
                            state_next = last_reg ? ST_SCALE : ST_IDLE;
                        end
                    end else begin
                        state_next = (eval_dx == '0) ? ST_PART : ST_INTERP;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SQ: begin
                ret_next   = ST_CROSS;
                state_next = ST_WAIT;
            end
            ST_CROSS, ST_TRAP, ST_PART: begin
                ret_next   = ST_ACC;
                state_next = ST_WAIT;
            end
            ST_INTERP: begin
                ret_next   = ST_PART;
                state_next = ST_WAIT;
            end
            ST_SCALE: begin
                ret_next   = ST_OUT;
                state_next = ST_WAIT;
            end
            ST_WAIT: if (md_rsp.done) begin
                state_next = ret_reg;
            end
            ST_ACC:  state_next = emit_reg ? ST_SCALE : ST_IDLE;
            ST_OUT: if (out_free) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath
    always_comb begin
        phase_next    = phase_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        acc_next      = acc_reg;
        sat_next      = sat_reg;
        x1_next       = x1_reg;
        y1_next       = y1_reg;
        last_next     = last_reg;
        y0_next       = y0_reg;
        dx_next       = dx_reg;
        alim_next     = alim_reg;
        tmp_next      = tmp_reg;
        neg_next      = neg_reg;
        emit_next     = emit_reg;
        stat_next     = stat_reg;
        area_next     = area_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        md_req        = '0;
        s_tready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    x1_next   = s_tdata[XW-1:0];
                    y1_next   = s_tdata[2*XW-1:XW];
                    last_next = s_tlast;
                end
            end
            ST_EVAL: begin
                dx_next   = eval_dx;
                alim_next = eval_alim;
                y0_next   = prev_y_reg;
                priority if (phase_reg == PH_SEARCH) begin
                    if (start_hit) begin
                        prev_x_next = x1_reg;
                        prev_y_next = y1_reg;
                        acc_next    = '0;
                        sat_next    = 1'b0;
                        phase_next  = PH_INTEG;
                        stat_next   = STAT_END;
                    end else begin
                        tmp_next  = '0;
                        stat_next = STAT_MISSING;
                    end
                end else if (phase_reg == PH_INTEG) begin
                    if (below_limit) begin
                        prev_x_next = x1_reg;
                        prev_y_next = y1_reg;
                        emit_next   = last_reg;
                        stat_next   = STAT_END;
                    end else begin
                        tmp_next   = '0;
                        emit_next  = 1'b1;
                        stat_next  = STAT_LIMIT;
                        phase_next = PH_DONE;
                    end
                end else begin
                    phase_next = phase_reg;
                end
                // end of curve rearms the search
                if (last_reg) begin
                    phase_next = PH_SEARCH;
                end
            end
            // y^2 of the positive end of a crossing segment
            ST_SQ: begin
                md_req.start = 1'b1;
                md_req.mode  = MD_MUL;
                md_req.a     = mag33({yp[XW-1], yp});
                md_req.b     = OPB_W'(mag33({yp[XW-1], yp}));
                neg_next     = 1'b0;
            end
            // triangle above zero: dx*yp^2 / (yp-yn)
            ST_CROSS: begin
                md_req.start = 1'b1;
                md_req.mode  = MD_DIV;
                md_req.a     = mag33(dx_reg);
                md_req.b     = tmp_reg;
                md_req.c     = OPB_W'(ygap) << FRAC_BITS;
                neg_next     = dx_reg[OPA_W-1];
            end
            // trapezoid: dx*(y0+y1)
            ST_TRAP: begin
                md_req.start = 1'b1;
                md_req.mode  = MD_SHIFT;
                md_req.a     = mag33(dx_reg);
                md_req.b     = OPB_W'(mag33(ysum));
                neg_next     = dx_reg[OPA_W-1] ^ ysum[OPA_W-1];
            end
            // interpolated rise up to the limit
            ST_INTERP: begin
                md_req.start = 1'b1;
                md_req.mode  = MD_DIV;
                md_req.a     = mag33(ydiff);
                md_req.b     = OPB_W'(mag33(alim_reg));
                md_req.c     = OPB_W'(mag33(dx_reg));
                neg_next     = ydiff[OPA_W-1] ^ alim_reg[OPA_W-1] ^ dx_reg[OPA_W-1];
            end
            // partial segment: a*(2*y0 + rise)
            ST_PART: begin
                md_req.start = 1'b1;
                md_req.mode  = MD_SHIFT;
                md_req.a     = mag33(alim_reg);
                md_req.b     = mag64(psum);
                neg_next     = alim_reg[OPA_W-1] ^ psum[OPB_W-1];
            end
            // output scaling
            ST_SCALE: begin
                md_req.start = 1'b1;
                md_req.mode  = MD_SHIFT;
                md_req.a     = mag33({scale_reg[XW-1], scale_reg});
                md_req.b     = mag64(acc_reg);
                neg_next     = scale_reg[XW-1] ^ acc_reg[OPB_W-1];
            end
            ST_WAIT: if (md_rsp.done) begin
                tmp_next = neg_reg ? -$signed(md_rsp.q) : $signed(md_rsp.q);
                sat_next = sat_reg | md_rsp.sat;
            end
            // saturating accumulate
            ST_ACC: begin
                if (acc_sum > ACC_HI) begin
                    acc_next = ACC_HI[OPB_W-1:0];
                    sat_next = 1'b1;
                end else if (acc_sum < ACC_LO) begin
                    acc_next = ACC_LO[OPB_W-1:0];
                    sat_next = 1'b1;
                end else begin
                    acc_next = acc_sum[OPB_W-1:0];
                end
            end
            // load the output register once it is free
            ST_OUT: if (out_free) begin
                area_next     = out_val[AREA_W-1:0];
                m_tvalid_next = 1'b1;
                if (stat_reg == STAT_MISSING) begin
                    status_next = STAT_MISSING;
                end else begin
                    sat_next    = sat_reg | out_ovf;
                    status_next = (sat_reg || out_ovf) ? STAT_SAT : stat_reg;
                end
            end
            default: ;
        endcase
    end

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= '0;
            upper_reg   <= UPPER_RESET;
            scale_reg   <= SCALE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_START_X: start_x_reg <= cfg_wdata;
                CFG_UPPER:   upper_reg   <= cfg_wdata;
                CFG_SCALE:   scale_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control and curve state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            phase_reg    <= PH_SEARCH;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            acc_reg      <= '0;
            sat_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            phase_reg    <= phase_next;
            prev_x_reg   <= prev_x_next;
            prev_y_reg   <= prev_y_next;
            acc_reg      <= acc_next;
            sat_reg      <= sat_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working registers and output word
    always_ff @(posedge aclk) begin
        x1_reg     <= x1_next;
        y1_reg     <= y1_next;
        last_reg   <= last_next;
        y0_reg     <= y0_next;
        dx_reg     <= dx_next;
        alim_reg   <= alim_next;
        tmp_reg    <= tmp_next;
        neg_reg    <= neg_next;
        emit_reg   <= emit_next;
        stat_reg   <= stat_next;
        area_reg   <= area_next;
        status_reg <= status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, status_reg, area_reg};

endmodule
